// ===== hdl/i2c_master_register_transfer_assert.svh =====
// assertion macros for the i2c master register transfer block
`ifndef I2C_MASTER_REGISTER_TRANSFER_ASSERT_SVH
`define I2C_MASTER_REGISTER_TRANSFER_ASSERT_SVH

// same-cycle implication, clocked on clk, quiet while in reset
`define I2CM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2c master check failed");

// next-cycle implication
`define I2CM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2c master check failed");

`endif

// ===== hdl/i2cm_pkg.sv =====
package i2cm_pkg;

  localparam int QDepth = 2;
  localparam int QAw    = 1;

  localparam logic [15:0] HalfPeriodReset = 16'd360;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_READ   = 2'd1,
    CMD_WRITE  = 2'd2,
    CMD_SUPPLY = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_START_A = 4'd1,
    PH_START_B = 4'd2,
    PH_RS_A    = 4'd3,
    PH_RS_B    = 4'd4,
    PH_ADDR_W  = 4'd5,
    PH_REG     = 4'd6,
    PH_ADDR_R  = 4'd7,
    PH_READ    = 4'd8,
    PH_WDATA   = 4'd9,
    PH_WAIT    = 4'd10,
    PH_STOP_A  = 4'd11,
    PH_STOP_B  = 4'd12
  } phase_t;

  // one classified request as it sits in the queue
  typedef struct packed {
    cmd_t       cmd;
    logic [6:0] target;
    logic [7:0] subaddr;
    logic [7:0] length;
    logic [7:0] data_byte;
    logic       sda_in;
  } item_t;

  // one result as it leaves the sequencer
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       want_byte;
    logic [7:0] read_data;
    logic       read_valid;
    logic       read_last;
    logic       done_res;
    logic       failed;
  } res_t;

  // queue head toward the sequencer
  typedef struct packed {
    logic  valid;
    item_t item;
  } qhead_t;

endpackage

// ===== hdl/i2cm_front.sv =====
module i2cm_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_mode,
  input  logic [6:0]       in_target,
  input  logic [7:0]       in_subaddr,
  input  logic [7:0]       in_length,
  input  logic [7:0]       in_data_byte,
  input  logic             in_sda_in,
  output i2cm_pkg::qhead_t head,
  input  logic             pop
);
  import i2cm_pkg::*;

  item_t              q_mem_r [QDepth];
  logic [QAw-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [QAw-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [QAw:0]       count_r, count_nxt;
  logic               push;
  logic               do_pop;
  item_t              item_in;
  cmd_t               cmd;

  // decode the mode code
  assign cmd = cmd_t'(in_mode);

  assign item_in = '{cmd: cmd, target: in_target, subaddr: in_subaddr,
                     length: in_length, data_byte: in_data_byte, sda_in: in_sda_in};

  assign in_stall = (count_r == (QAw+1)'(QDepth));
  assign push     = in_valid && !in_stall;
  assign do_pop   = pop && (count_r != '0);

  assign head.valid = (count_r != '0);
  assign head.item  = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push   ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + {{QAw{1'b0}}, push} - {{QAw{1'b0}}, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

// ===== hdl/i2cm_back.sv =====
module i2cm_back (
  input  logic             clk,
  input  logic             rst_n,
  input  i2cm_pkg::qhead_t head,
  output logic             pop,
  input  logic             cfg_we,
  input  logic [15:0]      cfg_data,
  output logic             out_valid,
  input  logic             out_stall,
  output i2cm_pkg::res_t   res
);
  import i2cm_pkg::*;

  typedef struct packed {
    phase_t     phase;
    logic [15:0] tick;
    logic [3:0]  bit_idx;
    logic [7:0]  shift;
    logic [7:0]  bytes_left;
    logic [6:0]  target;
    logic [7:0]  regaddr;
    logic        is_read;
    logic        pend_valid;
    logic        scl;
    logic        sda;
    logic        abort;
  } st_t;

  st_t         st_r, st_nxt;
  logic [7:0]  pend_byte_r, pend_byte_nxt;
  logic [15:0] half_period_r;
  logic        out_valid_r;
  res_t        res_r, res_nxt;
  logic [15:0] hp;
  logic        tick_more;
  logic [7:0]  shift_in;
  logic [3:0]  bit_inc;
  logic [7:0]  bl_dec;

  function automatic st_t begin_byte(st_t s, phase_t ph, logic [7:0] v);
    st_t t;
    t         = s;
    t.phase   = ph;
    t.shift   = v;
    t.bit_idx = '0;
    t.tick    = '0;
    t.scl     = 1'b0;
    t.sda     = (ph == PH_READ) ? 1'b1 : v[7];
    return t;
  endfunction

  function automatic st_t go_stop(st_t s, logic fail);
    st_t t;
    t       = s;
    t.phase = PH_STOP_A;
    t.tick  = '0;
    t.scl   = 1'b0;
    t.sda   = 1'b0;
    t.abort = fail;
    return t;
  endfunction

  function automatic st_t after_written(st_t s);
    st_t t;
    t = s;
    if (s.bytes_left == '0) begin
      t = go_stop(s, 1'b0);
    end else begin
      t.phase = PH_WAIT;
      t.tick  = '0;
      t.scl   = 1'b0;
    end
    return t;
  endfunction

  assign pop = head.valid && (!out_valid_r || !out_stall);

  assign hp        = (half_period_r == '0) ? 16'd1 : half_period_r;
  assign tick_more = ({1'b0, st_r.tick} + 17'd1) < {1'b0, hp};
  assign shift_in  = {st_r.shift[6:0], (st_r.phase == PH_READ) ? head.item.sda_in : 1'b0};
  assign bit_inc   = st_r.bit_idx + 4'd1;
  assign bl_dec    = st_r.bytes_left - 8'd1;

  always_comb begin
    st_nxt        = st_r;
    pend_byte_nxt = pend_byte_r;
    res_nxt       = '0;
    case (head.item.cmd)
      CMD_TICK: begin
        if (st_r.phase == PH_IDLE) begin
          st_nxt = st_r;
        end else if (st_r.phase == PH_WAIT) begin
          if (st_r.pend_valid) begin
            st_nxt            = begin_byte(st_r, PH_WDATA, pend_byte_r);
            st_nxt.pend_valid = 1'b0;
          end
        end else if (tick_more) begin
          st_nxt.tick = st_r.tick + 16'd1;
        end else begin
          st_nxt.tick = '0;
          case (st_r.phase)
            PH_START_A: begin
              st_nxt.sda   = 1'b0;
              st_nxt.phase = PH_START_B;
            end
            PH_RS_A: begin
              st_nxt.sda   = 1'b0;
              st_nxt.phase = PH_RS_B;
            end
            PH_START_B: st_nxt = begin_byte(st_nxt, PH_ADDR_W, {st_r.target, 1'b0});
            PH_RS_B:    st_nxt = begin_byte(st_nxt, PH_ADDR_R, {st_r.target, 1'b1});
            PH_STOP_A: begin
              st_nxt.scl   = 1'b1;
              st_nxt.phase = PH_STOP_B;
            end
            PH_STOP_B: begin
              st_nxt.sda        = 1'b1;
              st_nxt.phase      = PH_IDLE;
              st_nxt.pend_valid = 1'b0;
              st_nxt.abort      = 1'b0;
              res_nxt.done_res  = 1'b1;
              res_nxt.failed    = st_r.abort;
            end
            default: begin
              // byte phases: low half then high half with sampling at its end
              if (!st_r.scl) begin
                st_nxt.scl = 1'b1;
              end else begin
                st_nxt.scl = 1'b0;
                if (!st_r.bit_idx[3]) begin
                  st_nxt.shift   = shift_in;
                  st_nxt.bit_idx = bit_inc;
                  if (st_r.phase == PH_READ && st_r.bit_idx == 4'd7) begin
                    res_nxt.read_data  = shift_in;
                    res_nxt.read_valid = 1'b1;
                    res_nxt.read_last  = (st_r.bytes_left == 8'd1);
                  end
                  if (!bit_inc[3]) begin
                    st_nxt.sda = (st_r.phase == PH_READ) ? 1'b1 : shift_in[7];
                  end else if (st_r.phase == PH_READ) begin
                    st_nxt.sda = (st_r.bytes_left == 8'd1);
                  end else begin
                    st_nxt.sda = 1'b1;
                  end
                end else if (st_r.phase == PH_READ) begin
                  st_nxt.bytes_left = bl_dec;
                  if (bl_dec == '0) begin
                    st_nxt = go_stop(st_nxt, 1'b0);
                  end else begin
                    st_nxt = begin_byte(st_nxt, PH_READ, 8'd0);
                  end
                end else if (head.item.sda_in) begin
                  // target did not acknowledge
                  st_nxt = go_stop(st_nxt, 1'b1);
                end else begin
                  case (st_r.phase)
                    PH_ADDR_W: st_nxt = begin_byte(st_nxt, PH_REG, st_r.regaddr);
                    PH_REG: begin
                      if (st_r.is_read) begin
                        st_nxt.phase = PH_RS_A;
                        st_nxt.scl   = 1'b1;
                        st_nxt.sda   = 1'b1;
                      end else begin
                        st_nxt = after_written(st_nxt);
                      end
                    end
                    PH_ADDR_R: begin
                      if (st_r.bytes_left == '0) begin
                        st_nxt = go_stop(st_nxt, 1'b0);
                      end else begin
                        st_nxt = begin_byte(st_nxt, PH_READ, 8'd0);
                      end
                    end
                    default: begin
                      st_nxt.bytes_left = bl_dec;
                      st_nxt            = after_written(st_nxt);
                    end
                  endcase
                end
              end
            end
          endcase
        end
      end
      CMD_SUPPLY: begin
        if (st_r.phase != PH_IDLE && !st_r.is_read && !st_r.pend_valid) begin
          pend_byte_nxt     = head.item.data_byte;
          st_nxt.pend_valid = 1'b1;
        end
      end
      default: begin
        if (st_r.phase == PH_IDLE) begin
          st_nxt.target     = head.item.target;
          st_nxt.regaddr    = head.item.subaddr;
          st_nxt.bytes_left = head.item.length;
          st_nxt.is_read    = (head.item.cmd == CMD_READ);
          st_nxt.pend_valid = 1'b0;
          st_nxt.abort      = 1'b0;
          st_nxt.bit_idx    = '0;
          st_nxt.tick       = '0;
          st_nxt.scl        = 1'b1;
          st_nxt.sda        = 1'b1;
          st_nxt.phase      = PH_START_A;
        end
      end
    endcase
    res_nxt.scl_out   = st_nxt.scl;
    res_nxt.sda_out   = st_nxt.sda;
    res_nxt.busy_res  = (st_nxt.phase != PH_IDLE);
    res_nxt.want_byte = (st_nxt.phase == PH_WAIT) && !st_nxt.pend_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r          <= '{phase: PH_IDLE, scl: 1'b1, sda: 1'b1, default: '0};
      half_period_r <= HalfPeriodReset;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        half_period_r <= cfg_data;
      end
      if (pop) begin
        st_r <= st_nxt;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pend_byte_r <= pend_byte_nxt;
      res_r       <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule

// ===== hdl/i2c_master_register_transfer.sv =====
// i2c master for register transfers on open-drain scl and sda lines. every request is one
// step of the bus: a clock tick (mode 0) that advances bus timing and brings in the sampled
// sda level, a begin-read (mode 1) or begin-write (mode 2) command that latches device
// address, register address and byte count, or a write byte (mode 3) for the transfer in
// progress. each request gives exactly one result with the line drives, busy, want_byte,
// any received byte with its last flag, and done with a failure flag when the target did
// not acknowledge. a begin while busy is ignored, as is a write byte that has nowhere to go.
// half_period (reset 360, zero acts as one) sets ticks per half scl bit and is written over
// the cfg port; the user must do so only while the block is idle, which it does not enforce;
// cfg_ready is always high. timing: one request per clock while the result is not stalled,
// limited by the sequencer step (a 16-bit count compare and the phase update). a request
// waits in a two-entry input queue and its result is held in the result register; the input
// side keeps taking requests while a result is stalled until the queue fills.
module i2c_master_register_transfer (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [6:0]  in_target,
  input  logic [7:0]  in_subaddr,
  input  logic [7:0]  in_length,
  input  logic [7:0]  in_data_byte,
  input  logic        in_sda_in,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_scl_out,
  output logic        out_sda_out,
  output logic        out_busy_res,
  output logic        out_want_byte,
  output logic [7:0]  out_read_data,
  output logic        out_read_valid,
  output logic        out_read_last,
  output logic        out_done_res,
  output logic        out_failed,
  // half period register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import i2cm_pkg::*;

  qhead_t head;
  logic   pop;
  res_t   res;

  // always able to take a register write
  assign cfg_ready = 1'b1;

  // front: decode mode and hold requests in a short queue
  i2cm_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_target    (in_target),
    .in_subaddr   (in_subaddr),
    .in_length    (in_length),
    .in_data_byte (in_data_byte),
    .in_sda_in    (in_sda_in),
    .head         (head),
    .pop          (pop)
  );

  // back: bus sequencer, one step per popped request, results into the output register
  i2cm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  // result fields
  assign out_scl_out    = res.scl_out;
  assign out_sda_out    = res.sda_out;
  assign out_busy_res   = res.busy_res;
  assign out_want_byte  = res.want_byte;
  assign out_read_data  = res.read_data;
  assign out_read_valid = res.read_valid;
  assign out_read_last  = res.read_last;
  assign out_done_res   = res.done_res;
  assign out_failed     = res.failed;

endmodule

// ===== hdl/i2cm_checker.sv =====
`include "i2c_master_register_transfer_assert.svh"

module i2cm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_scl_out,
  input logic        out_sda_out,
  input logic        out_busy_res,
  input logic        out_want_byte,
  input logic [7:0]  out_read_data,
  input logic        out_read_valid,
  input logic        out_read_last,
  input logic        out_done_res,
  input logic        out_failed
);

  // a stalled result keeps its received byte
  `I2CM_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_read_data))

  // a finished transfer leaves both lines released
  `I2CM_ASSERT_IMP(a_done_idle, out_valid && out_done_res,
                   !out_busy_res && out_scl_out && out_sda_out)

  // failure is only reported with done
  `I2CM_ASSERT_IMP(a_fail_done, out_valid && out_failed, out_done_res)

  // a received byte arrives mid-transfer and last only marks a received byte
  `I2CM_ASSERT_IMP(a_read_busy, out_valid && (out_read_valid || out_read_last),
                   out_read_valid && out_busy_res)

  // waiting for write data holds scl low
  `I2CM_ASSERT_IMP(a_want_scl, out_valid && out_want_byte, out_busy_res && !out_scl_out)

endmodule

bind i2c_master_register_transfer i2cm_checker u_i2cm_checker (.*);
